// ===== hw/rtl/hrtok_pkg.sv =====
// Shared types and constants for the HTTP request header tokenizer.
`default_nettype none
package hrtok_pkg;

  typedef enum logic [3:0] {
    PhMethod   = 4'd0,
    PhUrlStart = 4'd1,
    PhPath     = 4'd2,
    PhQuery    = 4'd3,
    PhVersion  = 4'd4,
    PhKey      = 4'd5,
    PhValue    = 4'd6,
    PhBody     = 4'd7,
    PhError    = 4'd8
  } phase_e;

  typedef enum logic [2:0] {
    RgPrefix = 3'd0,
    RgFrom   = 3'd1,
    RgTo     = 3'd2,
    RgRest   = 3'd3,
    RgFail   = 3'd4
  } range_phase_e;

  localparam logic [3:0] TagDrop    = 4'd0;
  localparam logic [3:0] TagMethod  = 4'd1;
  localparam logic [3:0] TagPath    = 4'd2;
  localparam logic [3:0] TagQuery   = 4'd3;
  localparam logic [3:0] TagVersion = 4'd4;
  localparam logic [3:0] TagKey     = 4'd5;
  localparam logic [3:0] TagCtype   = 4'd6;
  localparam logic [3:0] TagClen    = 4'd7;
  localparam logic [3:0] TagConn    = 4'd8;
  localparam logic [3:0] TagIms     = 4'd9;
  localparam logic [3:0] TagRgFrom  = 4'd10;
  localparam logic [3:0] TagRgTo    = 4'd11;
  localparam logic [3:0] TagOther   = 4'd12;
  localparam logic [3:0] TagBody    = 4'd13;

  localparam logic [3:0] StRunning   = 4'd0;
  localparam logic [3:0] StAccepted  = 4'd1;
  localparam logic [3:0] StNoSpace   = 4'd2;
  localparam logic [3:0] StNoUrl     = 4'd3;
  localparam logic [3:0] StBadPath   = 4'd4;
  localparam logic [3:0] StNoUrlEnd  = 4'd5;
  localparam logic [3:0] StNoVersion = 4'd6;
  localparam logic [3:0] StVerNoEnd  = 4'd7;
  localparam logic [3:0] StNoColon   = 4'd8;
  localparam logic [3:0] StNoValue   = 4'd9;
  localparam logic [3:0] StValNoEnd  = 4'd10;

  localparam logic [4:0] RangeBit = 5'b01000;

  localparam logic [7:0] ChCr     = 8'h0d;
  localparam logic [7:0] ChLf     = 8'h0a;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChSlash  = 8'h2f;
  localparam logic [7:0] ChQmark  = 8'h3f;
  localparam logic [7:0] ChColon  = 8'h3a;
  localparam logic [7:0] ChHyphen = 8'h2d;
  localparam logic [7:0] ChComma  = 8'h2c;

  // One classified result plus its pass-through status fields.
  typedef struct packed {
    logic [7:0] data;
    logic [3:0] tag;
    logic       line_end;
    logic       range_ok;
    logic [3:0] status;
    logic       last;
  } result_t;

  // Up to two results caused by one input byte.
  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } entry_t;

  function automatic logic [4:0] key_len(input logic [2:0] k);
    logic [4:0] l;
    l = 5'd0;
    case (k)
      3'd0:    l = 5'd12;
      3'd1:    l = 5'd14;
      3'd2:    l = 5'd10;
      3'd3:    l = 5'd13;
      3'd4:    l = 5'd17;
      default: l = 5'd0;
    endcase
    return l;
  endfunction

  // Lower-case character of known name k at position p.
  function automatic logic [7:0] key_char(input logic [2:0] k, input logic [4:0] p);
    logic [8*17-1:0] s;
    logic [7:0] c;
    s = '0;
    c = 8'h00;
    case (k)
      3'd0:    s = {"content-type", 40'h0};
      3'd1:    s = {"content-length", 24'h0};
      3'd2:    s = {"connection", 56'h0};
      3'd3:    s = {"content-range", 32'h0};
      3'd4:    s = "if-modified-since";
      default: s = '0;
    endcase
    if (p < 5'd17) begin
      c = s[8*(16 - p) +: 8];
    end
    return c;
  endfunction

  function automatic logic [7:0] prefix_char(input logic [2:0] p);
    logic [7:0] c;
    c = 8'h00;
    case (p)
      3'd0:    c = "b";
      3'd1:    c = "y";
      3'd2:    c = "t";
      3'd3:    c = "e";
      3'd4:    c = "s";
      3'd5:    c = "=";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/hrtok_front.sv =====
// Front end: per-byte parse state machine producing up to two tagged results.
`default_nettype none
module hrtok_front #(
  parameter int unsigned KeyMatchLen = 17
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire logic [7:0]        in_byte_i,
  input  wire logic              last_byte_i,
  output logic                   push_o,
  input  wire logic              full_i,
  output hrtok_pkg::entry_t      entry_o
);

  localparam int unsigned KpW = $clog2(KeyMatchLen + 1);

  hrtok_pkg::phase_e       phase_q, phase_d;
  hrtok_pkg::range_phase_e rg_q, rg_d;
  logic [4:0]     kmb_q, kmb_d;
  logic [KpW-1:0] kpos_q, kpos_d;
  logic [2:0]     ppos_q, ppos_d;
  logic           held_q, held_d;
  logic           lhc_q, lhc_d;
  logic           hyph_q, hyph_d;
  logic [3:0]     st_q, st_d;

  logic fire;
  assign ready_o = !full_i;
  assign fire    = valid_i && ready_o;

  // Working copies updated through the two sequential classify steps.
  hrtok_pkg::phase_e       ph;
  hrtok_pkg::range_phase_e rg;
  logic [4:0]     kmb;
  logic [KpW-1:0] kpos;
  logic [2:0]     ppos;
  logic           lhc, hyph;
  logic [3:0]     st;

  logic [7:0] r_data [2];
  logic [3:0] r_tag  [2];
  logic       r_le   [2];
  logic       r_rok  [2];
  logic [1:0] nres;

  function automatic logic [4:0] key_step(input logic [4:0] m, input logic [KpW-1:0] p,
                                          input logic [7:0] c);
    logic [4:0] r;
    r = m;
    for (int i = 0; i < 5; i++) begin
      if (m[i]) begin
        if ({{(32-KpW){1'b0}}, p} >= 32'(hrtok_pkg::key_len(3'(i))) ||
            hrtok_pkg::to_lower(c) != hrtok_pkg::key_char(3'(i), 5'(p))) begin
          r[i] = 1'b0;
        end
      end
    end
    return r;
  endfunction

  always_comb begin
    logic [7:0] c;
    logic       do_held;
    logic       do_cur;
    logic       hold_new;
    logic [3:0] t;
    logic       le, rok;
    ph = phase_q; rg = rg_q; kmb = kmb_q; kpos = kpos_q; ppos = ppos_q;
    lhc = lhc_q; hyph = hyph_q; st = st_q;
    nres = 2'd0;
    c = 8'h00; t = 4'd0; le = 1'b0; rok = 1'b0;
    for (int j = 0; j < 2; j++) begin
      r_data[j] = 8'h00; r_tag[j] = 4'd0; r_le[j] = 1'b0; r_rok[j] = 1'b0;
    end
    do_held = held_q;
    hold_new = 1'b0;
    do_cur = 1'b1;
    for (int s = 0; s < 2; s++) begin
      logic act;
      act = 1'b0;
      if (s == 0) begin
        if (do_held) begin
          if (in_byte_i == hrtok_pkg::ChLf) begin
            r_data[0] = hrtok_pkg::ChCr; r_tag[0] = hrtok_pkg::TagDrop;
            nres = 2'd1;
          end else begin
            act = 1'b1;
            c = hrtok_pkg::ChCr;
          end
        end
      end else begin
        if (in_byte_i == hrtok_pkg::ChCr && !last_byte_i &&
            (ph == hrtok_pkg::PhVersion || ph == hrtok_pkg::PhValue ||
             (ph == hrtok_pkg::PhKey && !lhc))) begin
          hold_new = 1'b1;
        end else begin
          act = do_cur;
          c = in_byte_i;
        end
      end
      if (act) begin
        t = hrtok_pkg::TagDrop; le = 1'b0; rok = 1'b0;
        unique case (ph)
          hrtok_pkg::PhMethod: begin
            if (c == hrtok_pkg::ChSpace) ph = hrtok_pkg::PhUrlStart;
            else t = hrtok_pkg::TagMethod;
          end
          hrtok_pkg::PhUrlStart: begin
            if (c == hrtok_pkg::ChSlash) begin
              t = hrtok_pkg::TagPath; ph = hrtok_pkg::PhPath;
            end else begin
              ph = hrtok_pkg::PhError; st = hrtok_pkg::StBadPath;
            end
          end
          hrtok_pkg::PhPath, hrtok_pkg::PhQuery: begin
            if (c == hrtok_pkg::ChSpace) begin
              ph = hrtok_pkg::PhVersion; lhc = 1'b0;
            end else if (c == hrtok_pkg::ChQmark && ph == hrtok_pkg::PhPath) begin
              ph = hrtok_pkg::PhQuery;
            end else begin
              t = (ph == hrtok_pkg::PhPath) ? hrtok_pkg::TagPath : hrtok_pkg::TagQuery;
            end
          end
          hrtok_pkg::PhVersion: begin
            if (c == hrtok_pkg::ChLf) begin
              le = 1'b1;
              ph = hrtok_pkg::PhKey; lhc = 1'b0; kmb = 5'h1f; kpos = '0;
            end else begin
              t = hrtok_pkg::TagVersion; lhc = 1'b1;
            end
          end
          hrtok_pkg::PhKey: begin
            if (!lhc && c == hrtok_pkg::ChLf) begin
              le = 1'b1; ph = hrtok_pkg::PhBody; st = hrtok_pkg::StAccepted;
            end else if (c == hrtok_pkg::ChColon) begin
              for (int i = 0; i < 5; i++) begin
                if ({{(32-KpW){1'b0}}, kpos} != 32'(hrtok_pkg::key_len(3'(i)))) begin
                  kmb[i] = 1'b0;
                end
              end
              ph = hrtok_pkg::PhValue; lhc = 1'b0; rg = hrtok_pkg::RgPrefix;
              ppos = 3'd0; hyph = 1'b0;
            end else begin
              lhc = 1'b1;
              kmb = key_step(kmb, kpos, c);
              if ({{(32-KpW){1'b0}}, kpos} < KeyMatchLen) kpos = kpos + 1'b1;
              t = hrtok_pkg::TagKey;
            end
          end
          hrtok_pkg::PhValue: begin
            if (c == hrtok_pkg::ChLf) begin
              le = 1'b1;
              rok = (kmb == hrtok_pkg::RangeBit) && hyph &&
                    (rg == hrtok_pkg::RgFrom || rg == hrtok_pkg::RgTo ||
                     rg == hrtok_pkg::RgRest);
              ph = hrtok_pkg::PhKey; lhc = 1'b0; kmb = 5'h1f; kpos = '0;
            end else if (!lhc && c == hrtok_pkg::ChSpace) begin
              t = hrtok_pkg::TagDrop;
            end else begin
              lhc = 1'b1;
              if (kmb == hrtok_pkg::RangeBit) begin
                case (rg)
                  hrtok_pkg::RgPrefix: begin
                    if (ppos < 3'd6 && c == hrtok_pkg::prefix_char(ppos)) begin
                      ppos = ppos + 3'd1;
                      if (ppos == 3'd6) rg = hrtok_pkg::RgFrom;
                    end else begin
                      rg = hrtok_pkg::RgFail;
                    end
                  end
                  hrtok_pkg::RgFrom: begin
                    if (c == hrtok_pkg::ChHyphen) begin
                      hyph = 1'b1; rg = hrtok_pkg::RgTo;
                    end else t = hrtok_pkg::TagRgFrom;
                  end
                  hrtok_pkg::RgTo: begin
                    if (c == hrtok_pkg::ChComma) rg = hrtok_pkg::RgRest;
                    else t = hrtok_pkg::TagRgTo;
                  end
                  default: t = hrtok_pkg::TagDrop;
                endcase
              end else if (kmb == 5'h01) t = hrtok_pkg::TagCtype;
              else if (kmb == 5'h02) t = hrtok_pkg::TagClen;
              else if (kmb == 5'h04) t = hrtok_pkg::TagConn;
              else if (kmb == 5'h10) t = hrtok_pkg::TagIms;
              else t = hrtok_pkg::TagOther;
            end
          end
          hrtok_pkg::PhBody: t = hrtok_pkg::TagBody;
          default: t = hrtok_pkg::TagDrop;
        endcase
        r_data[nres[0]] = c; r_tag[nres[0]] = t;
        r_le[nres[0]] = le; r_rok[nres[0]] = rok;
        nres = nres + 2'd1;
      end
    end
    if (last_byte_i) begin
      unique case (ph)
        hrtok_pkg::PhMethod:   begin ph = hrtok_pkg::PhError; st = hrtok_pkg::StNoSpace; end
        hrtok_pkg::PhUrlStart: begin ph = hrtok_pkg::PhError; st = hrtok_pkg::StNoUrl; end
        hrtok_pkg::PhPath, hrtok_pkg::PhQuery: begin
          ph = hrtok_pkg::PhError; st = hrtok_pkg::StNoUrlEnd;
        end
        hrtok_pkg::PhVersion: begin
          ph = hrtok_pkg::PhError;
          st = lhc ? hrtok_pkg::StVerNoEnd : hrtok_pkg::StNoVersion;
        end
        hrtok_pkg::PhKey: begin
          if (lhc) begin
            ph = hrtok_pkg::PhError; st = hrtok_pkg::StNoColon;
          end else begin
            ph = hrtok_pkg::PhBody; st = hrtok_pkg::StAccepted;
          end
        end
        hrtok_pkg::PhValue: begin
          ph = hrtok_pkg::PhError;
          st = lhc ? hrtok_pkg::StValNoEnd : hrtok_pkg::StNoValue;
        end
        default: ph = ph;
      endcase
    end
    held_d = hold_new;
    phase_d = ph; rg_d = rg; kmb_d = kmb; kpos_d = kpos; ppos_d = ppos;
    lhc_d = lhc; hyph_d = hyph; st_d = st;
  end

  always_comb begin
    entry_o = '0;
    entry_o.two = (nres == 2'd2);
    entry_o.first.data = r_data[0];
    entry_o.first.tag = r_tag[0];
    entry_o.first.line_end = r_le[0];
    entry_o.first.range_ok = r_rok[0];
    entry_o.first.status = st_d;
    entry_o.first.last = (nres == 2'd1);
    entry_o.second.data = r_data[1];
    entry_o.second.tag = r_tag[1];
    entry_o.second.line_end = r_le[1];
    entry_o.second.range_ok = r_rok[1];
    entry_o.second.status = st_d;
    entry_o.second.last = 1'b1;
  end

  assign push_o = fire && (nres != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= hrtok_pkg::PhMethod;
      rg_q    <= hrtok_pkg::RgPrefix;
      kmb_q   <= 5'h1f;
      kpos_q  <= '0;
      ppos_q  <= 3'd0;
      held_q  <= 1'b0;
      lhc_q   <= 1'b0;
      hyph_q  <= 1'b0;
      st_q    <= hrtok_pkg::StRunning;
    end else if (fire) begin
      phase_q <= phase_d;
      rg_q    <= rg_d;
      kmb_q   <= kmb_d;
      kpos_q  <= kpos_d;
      ppos_q  <= ppos_d;
      held_q  <= held_d;
      lhc_q   <= lhc_d;
      hyph_q  <= hyph_d;
      st_q    <= st_d;
    end
  end

`ifndef ASSERT_OFF
  a_held_only_cr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(held_q) |-> $past(in_byte_i) == hrtok_pkg::ChCr)
    else $error("held CR set by non-CR byte");
  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(st_q) != hrtok_pkg::StRunning |-> $stable(st_q))
    else $error("status changed after final");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !full_i)
    else $error("push into full queue");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/hrtok_queue.sv =====
// Small entry queue between the classifier and the result serializer.
`default_nettype none
module hrtok_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire hrtok_pkg::entry_t entry_i,
  output logic                   full_o,
  output logic                   empty_o,
  input  wire logic              pop_i,
  output hrtok_pkg::entry_t      entry_o
);

  hrtok_pkg::entry_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign entry_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

`ifndef ASSERT_OFF
  a_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("queue overflow");
  a_no_under: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("queue underflow");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/hrtok_back.sv =====
// Back end: serializes queued entries into one result per transfer.
`default_nettype none
module hrtok_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              empty_i,
  input  wire hrtok_pkg::entry_t entry_i,
  output logic                   pop_o,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output hrtok_pkg::result_t     res_o
);

  logic sel_q;

  assign valid_o = !empty_i;
  assign res_o   = sel_q ? entry_i.second : entry_i.first;
  assign pop_o   = valid_o && ready_i && (sel_q || !entry_i.two);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else if (valid_o && ready_i) begin
      sel_q <= !sel_q && entry_i.two;
    end
  end

`ifndef ASSERT_OFF
  a_sel_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q |-> entry_i.two && valid_o) else $error("second half without pair");
  a_last_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> res_o.last) else $error("pop without last result");
  a_sel_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q && !ready_i |=> sel_q) else $error("selection lost under stall");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/http_request_header_tokenizer_core.sv =====
// Top level of the HTTP request header tokenizer.
//
//   Channel  Direction  Handshake          Payload
//   in       input      in_valid/in_ready  in_byte, last_byte
//   out      output     out_valid/out_ready out_byte, field_tag, line_end,
//                                          range_ok, parse_status, last_result
//
// One byte per cycle enters; one result leaves per cycle while out_ready is high;
// two-result bytes send first, then second. Results come from the queue registers.
// A two-entry queue decouples parser and output; input stalls only when it is full.
// Reset returns the parser to the method phase with status running.
`default_nettype none
module http_request_header_tokenizer_core #(
  parameter int unsigned KEY_MATCH_LEN = 17
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       last_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic [3:0]      field_tag_o,
  output logic            line_end_o,
  output logic            range_ok_o,
  output logic [3:0]      parse_status_o,
  output logic            last_result_o
);

  logic push, full, empty, pop;
  hrtok_pkg::entry_t  ent_in, ent_out;
  hrtok_pkg::result_t res;

  hrtok_front #(.KeyMatchLen(KEY_MATCH_LEN)) u_front (
    .clk_i, .rst_ni,
    .valid_i(in_valid_i), .ready_o(in_ready_o),
    .in_byte_i, .last_byte_i,
    .push_o(push), .full_i(full), .entry_o(ent_in)
  );

  hrtok_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .entry_i(ent_in), .full_o(full), .empty_o(empty),
    .pop_i(pop), .entry_o(ent_out)
  );

  hrtok_back u_back (
    .clk_i, .rst_ni,
    .empty_i(empty), .entry_i(ent_out), .pop_o(pop),
    .valid_o(out_valid_o), .ready_i(out_ready_i), .res_o(res)
  );

  assign out_byte_o     = res.data;
  assign field_tag_o    = res.tag;
  assign line_end_o     = res.line_end;
  assign range_ok_o     = res.range_ok;
  assign parse_status_o = res.status;
  assign last_result_o  = res.last;

endmodule
`default_nettype wire
